// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared widths, constants and helpers for the radix integer-to-ascii block
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W    = 64;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 6;
  localparam int MAX_DIGITS = 64;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W     = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_LETTER   = CHAR_W'(55);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic store;
    logic rd_mem;
  } itoa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_done;
    logic conv_done;
    logic last;
  } itoa_sts_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DECIMAL_LIMIT) begin
      res = CHAR_W'(d) + CHAR_ZERO;
    end else begin
      res = CHAR_W'(d) + CHAR_LETTER;
    end
    return res;
  endfunction

endpackage

// File: rtl/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa channel interfaces
// valid/ready channels for the number input and the character output
// ----------------------------------------------------------------------------
interface itoa_num_if import itoa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, value, radix, input ready);
  modport sink   (input valid, value, radix, output ready);
endinterface

interface itoa_char_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, digit_char, last, input ready);
  modport sink   (input valid, digit_char, last, output ready);
endinterface

// File: rtl/radix_integer_to_ascii.sv
// per digit the divider runs in the divide state and the digit is written in the store state,
// then each is read and shown, a beat held until out_ready; worst case 64 digits
// the 64-step shift-subtract divider, one quotient bit per cycle, sets the rate
// one item at a time; the next value is taken after the last beat goes out
// rst is synchronous, active high, and returns the block to idle
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// converts an unsigned 64-bit value to ascii digits in radix 2 to 36,
// one character per beat, most significant digit first, last flag on the end
// ----------------------------------------------------------------------------
module radix_integer_to_ascii import itoa_pkg::*; (
  input logic         clk,
  input logic         rst,
  itoa_num_if.sink    num,
  itoa_char_if.source chars
);

  // command and status between sequencer and datapath
  itoa_cmd_t cmd;
  itoa_sts_t sts;

  // sequencer: idle, divide, store digit, read digit, present beat
  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num.valid),
    .in_ready  (num.ready),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: divider, digit store, output register
  itoa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (num.value),
    .radix_in   (num.radix),
    .sts        (sts),
    .digit_char (chars.digit_char),
    .last       (chars.last)
  );

  // a value is never taken while a conversion is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (num.valid && num.ready) |=> !num.ready)
    else $error("input accepted while busy");

  // after the final beat the block is idle again
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready && chars.last) |=> (num.ready && !chars.valid))
    else $error("not idle after final beat");

  // no character is presented while the block waits for input
  a_no_output_when_idle: assert property (@(posedge clk) disable iff (rst)
    num.ready |-> !chars.valid)
    else $error("output valid while idle");

endmodule

// File: rtl/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// sequencer: accept, divide digit by digit, then read digits out msd first
// ----------------------------------------------------------------------------
module itoa_ctrl import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  itoa_sts_t sts,
  output itoa_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_STORE = 5'b00100,
    S_READ  = 5'b01000,
    S_SHOW  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.step_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = sts.conv_done ? S_READ : S_DIV;
      end
      S_READ: begin
        cmd.rd_mem = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = sts.last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// shift-subtract divider, digit store and output character register
// ----------------------------------------------------------------------------
module itoa_dp import itoa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  itoa_cmd_t          cmd,
  input  logic [VALUE_W-1:0] value,
  input  logic [RADIX_W-1:0] radix_in,
  output itoa_sts_t          sts,
  output logic [CHAR_W-1:0]  digit_char,
  output logic               last
);

  logic [VALUE_W-1:0] quotient;
  logic [DIGIT_W-1:0] rem;
  logic [RADIX_W-1:0] radix;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   rd_ptr;
  logic               last_q;
  logic [DIGIT_W-1:0] rd_data;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];

  // one restoring division step
  logic [DIGIT_W:0]   trial;
  logic               ge;
  logic [DIGIT_W-1:0] rem_next;

  assign trial    = {rem, quotient[VALUE_W-1]};
  assign ge       = trial >= {1'b0, radix};
  assign rem_next = ge ? DIGIT_W'(trial - {1'b0, radix}) : DIGIT_W'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient <= '0;
      rem      <= '0;
      radix    <= RADIX_MIN;
      step     <= '0;
      count    <= '0;
      last_q   <= 1'b0;
    end else begin
      if (cmd.load) begin
        quotient <= value;
        radix    <= clamp_radix(radix_in);
        rem      <= '0;
        step     <= '0;
        count    <= '0;
      end
      if (cmd.step) begin
        quotient <= {quotient[VALUE_W-2:0], ge};
        rem      <= rem_next;
        step     <= step + STEP_W'(1);
      end
      if (cmd.store) begin
        count <= count + CNT_W'(1);
        rem   <= '0;
        step  <= '0;
      end
      if (cmd.rd_mem) begin
        last_q <= (rd_ptr == '0);
      end
    end
  end

  // read pointer walks down from the most significant digit
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rd_ptr <= count[IDX_W-1:0];
    end else if (cmd.rd_mem) begin
      rd_ptr <= rd_ptr - IDX_W'(1);
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_store[count[IDX_W-1:0]] <= rem;
    end
    if (cmd.rd_mem) begin
      rd_data <= digit_store[rd_ptr];
    end
  end

  assign sts.step_done = (step == STEP_W'(VALUE_W - 1));
  assign sts.conv_done = (quotient == '0) || (count == CNT_W'(MAX_DIGITS - 1));
  assign sts.last      = last_q;
  assign digit_char    = digit_to_ascii(rd_data);
  assign last          = last_q;

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    rem < radix)
    else $error("partial remainder not below radix");

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    (radix >= RADIX_MIN) && (radix <= RADIX_MAX))
    else $error("held radix out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (count < CNT_W'(MAX_DIGITS)))
    else $error("digit store overflow");

endmodule
